[hdl/d2c_pkg.sv]
// Shared types and constants for the depth-to-color reprojection block.
// No dependencies; used by depth_to_color_pixel_reprojection.
`timescale 1ns / 1ps
`default_nettype none

package d2c_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_A00_A01 = 3'd0;
	localparam logic [2:0] REG_A02_A10 = 3'd1;
	localparam logic [2:0] REG_A11_A12 = 3'd2;
	localparam logic [2:0] REG_A20_A21 = 3'd3;
	localparam logic [2:0] REG_A22_B0  = 3'd4;
	localparam logic [2:0] REG_B1_B2   = 3'd5;
	localparam logic [2:0] REG_WIDTH   = 3'd6;
	localparam logic [2:0] REG_HEIGHT  = 3'd7;

	// Reset values: identity matrix in Q11.20, VGA colour frame
	localparam logic [63:0] Q20_ONE_PAIR = 64'd1048576;
	localparam logic [12:0] WIDTH_RST    = 13'd640;
	localparam logic [12:0] HEIGHT_RST   = 13'd480;

	// Coordinate field range limits the image bound to 4096
	localparam int COORD_LIMIT = 4096;

	// Quotient bits resolved by the divider (quotients >= 2^13 never fit)
	localparam int QBITS = 13;
	// Magnitude width of U, V and W (|value| < 2^61)
	localparam int MAGW  = 62;

	// Payload that travels through the divider stages
	typedef struct packed {
		logic [MAGW-1:0]  rem_u;
		logic [MAGW-1:0]  rem_v;
		logic [MAGW-1:0]  dvs;
		logic [QBITS-1:0] q_u;
		logic [QBITS-1:0] q_v;
		logic             neg_u;
		logic             neg_v;
		logic             ovf_u;
		logic             ovf_v;
		logic             drop;
		logic [15:0]      depth;
	} div_t;

endpackage

`default_nettype wire

[hdl/depth_to_color_pixel_reprojection.sv]
// Top level of the depth-to-color reprojection pipeline.
// Depends on d2c_pkg (types, register indexes, reset values).
//
// Takes one depth pixel per beat and, when it lands inside the colour frame,
// presents one write beat (u, v, depth) through 20 register stages; pixels
// that fall outside, or whose W is zero, give no beat. A new pixel is taken
// every cycle unless the output stalls: the path is six arithmetic stages
// (products, row sums, depth multiply, offset add, magnitudes, range check)
// followed by a restoring divider of 13 one-bit stages that works U/W and
// V/W side by side, and an output register. The whole pipe holds when the
// output register is full and not taken. Configuration is to be written by the
// user through cfg_we/cfg_index/cfg_data while idle; the block does not check.
`timescale 1ns / 1ps
`default_nettype none

module depth_to_color_pixel_reprojection #(
	parameter int MAX_IMAGE_DIM = 4096
) (
	input  wire         clk,
	input  wire         arst_n,
	// Input stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,   // depth_x[11:0], depth_y[23:12], depth_mm[39:24]
	// Output stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // color_u[11:0], color_v[23:12], aligned_depth[39:24]
	// Configuration
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [63:0] cfg_data
);

	localparam int MAGW  = d2c_pkg::MAGW;
	localparam int QBITS = d2c_pkg::QBITS;
	localparam int LIM   = (MAX_IMAGE_DIM < d2c_pkg::COORD_LIMIT) ?
	                       MAX_IMAGE_DIM : d2c_pkg::COORD_LIMIT;
	localparam logic [12:0] LIM13 = 13'(LIM);
	localparam logic [14:0] MAXD  = 15'(MAX_IMAGE_DIM);

	// Configuration registers
	logic [63:0] coef_q [0:5];
	logic [12:0] width_q;
	logic [12:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= d2c_pkg::Q20_ONE_PAIR;
			coef_q[1] <= '0;
			coef_q[2] <= d2c_pkg::Q20_ONE_PAIR;
			coef_q[3] <= '0;
			coef_q[4] <= d2c_pkg::Q20_ONE_PAIR;
			coef_q[5] <= '0;
			width_q   <= d2c_pkg::WIDTH_RST;
			height_q  <= d2c_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				d2c_pkg::REG_A00_A01: coef_q[0] <= cfg_data;
				d2c_pkg::REG_A02_A10: coef_q[1] <= cfg_data;
				d2c_pkg::REG_A11_A12: coef_q[2] <= cfg_data;
				d2c_pkg::REG_A20_A21: coef_q[3] <= cfg_data;
				d2c_pkg::REG_A22_B0:  coef_q[4] <= cfg_data;
				d2c_pkg::REG_B1_B2:   coef_q[5] <= cfg_data;
				d2c_pkg::REG_WIDTH:   width_q   <= cfg_data[12:0];
				d2c_pkg::REG_HEIGHT:  height_q  <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// Coefficient fields
	logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22, b0, b1, b2;
	assign a00 = coef_q[0][31:0];
	assign a01 = coef_q[0][63:32];
	assign a02 = coef_q[1][31:0];
	assign a10 = coef_q[1][63:32];
	assign a11 = coef_q[2][31:0];
	assign a12 = coef_q[2][63:32];
	assign a20 = coef_q[3][31:0];
	assign a21 = coef_q[3][63:32];
	assign a22 = coef_q[4][31:0];
	assign b0  = coef_q[4][63:32];
	assign b1  = coef_q[5][31:0];
	assign b2  = coef_q[5][63:32];

	// Global advance: the pipe moves unless the output beat is stuck
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	logic [11:0] in_x, in_y;
	logic [15:0] in_z;
	assign in_x = s_tdata[11:0];
	assign in_y = s_tdata[23:12];
	assign in_z = s_tdata[39:24];

	// Stage 1: column and row products
	logic               vld_s1, drop_s1;
	logic [15:0]        z_s1;
	logic signed [44:0] p00_s1, p01_s1, p10_s1, p11_s1, p20_s1, p21_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drop_s1 <= ({3'b0, in_x} >= MAXD) || ({3'b0, in_y} >= MAXD);
			z_s1    <= in_z;
			p00_s1  <= a00 * $signed({1'b0, in_x});
			p01_s1  <= a01 * $signed({1'b0, in_y});
			p10_s1  <= a10 * $signed({1'b0, in_x});
			p11_s1  <= a11 * $signed({1'b0, in_y});
			p20_s1  <= a20 * $signed({1'b0, in_x});
			p21_s1  <= a21 * $signed({1'b0, in_y});
		end
	end

	// Stage 2: row sums
	logic               vld_s2, drop_s2;
	logic [15:0]        z_s2;
	logic signed [46:0] tu_s2, tv_s2, tw_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drop_s2 <= drop_s1;
			z_s2    <= z_s1;
			tu_s2   <= 47'(p00_s1) + 47'(p01_s1) + 47'(a02);
			tv_s2   <= 47'(p10_s1) + 47'(p11_s1) + 47'(a12);
			tw_s2   <= 47'(p20_s1) + 47'(p21_s1) + 47'(a22);
		end
	end

	// Stage 3: scale by depth
	logic               vld_s3, drop_s3;
	logic signed [63:0] mu_s3, mv_s3, mw_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drop_s3 <= drop_s2;
			mu_s3   <= tu_s2 * $signed({1'b0, z_s2});
			mv_s3   <= tv_s2 * $signed({1'b0, z_s2});
			mw_s3   <= tw_s2 * $signed({1'b0, z_s2});
		end
	end

	// Stage 4: add offsets (Q.8 to Q.20)
	logic               vld_s4, drop_s4;
	logic signed [63:0] cu_s4, cv_s4, cw_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drop_s4 <= drop_s3;
			cu_s4   <= mu_s3 + (64'(b0) <<< 12);
			cv_s4   <= mv_s3 + (64'(b1) <<< 12);
			cw_s4   <= mw_s3 + (64'(b2) <<< 12);
		end
	end

	// Stage 5: magnitudes, signs, depth result
	logic            vld_s5, drop_s5, neg_u_s5, neg_v_s5;
	logic [MAGW-1:0] mag_u_s5, mag_v_s5, mag_w_s5;
	logic [15:0]     depth_s5;
	logic [63:0]     abs_u, abs_v, abs_w;

	assign abs_u = cu_s4[63] ? -cu_s4 : cu_s4;
	assign abs_v = cv_s4[63] ? -cv_s4 : cv_s4;
	assign abs_w = cw_s4[63] ? -cw_s4 : cw_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (adv) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drop_s5  <= drop_s4 || (cw_s4 == 64'sd0);
			neg_u_s5 <= cu_s4[63] ^ cw_s4[63];
			neg_v_s5 <= cv_s4[63] ^ cw_s4[63];
			mag_u_s5 <= abs_u[MAGW-1:0];
			mag_v_s5 <= abs_v[MAGW-1:0];
			mag_w_s5 <= abs_w[MAGW-1:0];
			// Negative W gives zero depth; otherwise floor(W/2^20), saturated
			if (cw_s4[63])
				depth_s5 <= '0;
			else if (|cw_s4[62:36])
				depth_s5 <= 16'hFFFF;
			else
				depth_s5 <= cw_s4[35:20];
		end
	end

	// Stage 6: quotient overflow check (quotient >= 2^13 never fits)
	localparam int DW = MAGW + QBITS;
	logic [DW-1:0] dvs_top;
	assign dvs_top = {mag_w_s5, {QBITS{1'b0}}};

	logic          div_vld [0:QBITS];
	d2c_pkg::div_t div_st  [0:QBITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_vld[0] <= 1'b0;
		else if (adv) div_vld[0] <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_st[0].rem_u <= mag_u_s5;
			div_st[0].rem_v <= mag_v_s5;
			div_st[0].dvs   <= mag_w_s5;
			div_st[0].q_u   <= '0;
			div_st[0].q_v   <= '0;
			div_st[0].neg_u <= neg_u_s5;
			div_st[0].neg_v <= neg_v_s5;
			div_st[0].ovf_u <= {{QBITS{1'b0}}, mag_u_s5} >= dvs_top;
			div_st[0].ovf_v <= {{QBITS{1'b0}}, mag_v_s5} >= dvs_top;
			div_st[0].drop  <= drop_s5;
			div_st[0].depth <= depth_s5;
		end
	end

	// Stages 7 to 19: one restoring quotient bit per stage, MSB first
	for (genvar k = 0; k < QBITS; k++) begin : g_div
		localparam int SH = QBITS - 1 - k;
		logic [DW-1:0] trial;
		logic [DW-1:0] ru, rv;
		logic          ge_u, ge_v;
		logic [DW-1:0] du, dv;
		d2c_pkg::div_t nxt;

		assign trial = {{QBITS{1'b0}}, div_st[k].dvs} << SH;
		assign ru    = {{QBITS{1'b0}}, div_st[k].rem_u};
		assign rv    = {{QBITS{1'b0}}, div_st[k].rem_v};
		assign ge_u  = ru >= trial;
		assign ge_v  = rv >= trial;
		assign du    = ru - trial;
		assign dv    = rv - trial;

		// Next payload: remainders and one quotient bit updated
		always_comb begin
			nxt         = div_st[k];
			nxt.rem_u   = ge_u ? du[MAGW-1:0] : div_st[k].rem_u;
			nxt.rem_v   = ge_v ? dv[MAGW-1:0] : div_st[k].rem_v;
			nxt.q_u[SH] = ge_u;
			nxt.q_v[SH] = ge_v;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_vld[k+1] <= 1'b0;
			else if (adv) div_vld[k+1] <= div_vld[k];
		end

		always_ff @(posedge clk) begin
			if (adv)
				div_st[k+1] <= nxt;
		end
	end

	// Output: bound check and write beat
	logic [12:0]   bnd_u, bnd_v;
	logic          ok_u, ok_v, emit;
	d2c_pkg::div_t fin;

	assign fin   = div_st[QBITS];
	assign bnd_u = (width_q > LIM13) ? LIM13 : width_q;
	assign bnd_v = (height_q > LIM13) ? LIM13 : height_q;
	assign ok_u  = !fin.ovf_u && !(fin.neg_u && fin.q_u != '0) && (fin.q_u < bnd_u);
	assign ok_v  = !fin.ovf_v && !(fin.neg_v && fin.q_v != '0) && (fin.q_v < bnd_v);
	assign emit  = div_vld[QBITS] && !fin.drop && ok_u && ok_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (adv) m_tvalid <= emit;
	end

	always_ff @(posedge clk) begin
		if (adv)
			m_tdata <= {fin.depth, fin.q_v[11:0], fin.q_u[11:0]};
	end

endmodule

`default_nettype wire
